[src/edge_trigger_and_frequency_finder_assert.svh]
// Assertion macros for the edge trigger and frequency finder.
`ifndef EDGE_TRIGGER_AND_FREQUENCY_FINDER_ASSERT_SVH
`define EDGE_TRIGGER_AND_FREQUENCY_FINDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ETF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ETF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ETF_ASSERT(lbl, clk, rstn, prop, msg)

`define ETF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[src/etf_pkg.sv]
// Package with beat types, constants and sequencer states of the edge trigger block.
package etf_pkg;

  localparam int WindowLen  = 256;
  localparam int CaptureLen = 1024;
  localparam int SampleBits = 12;

  localparam int IdxW    = 16;
  localparam int LevelW  = 12;
  localparam int ModeW   = 2;
  localparam int TbW     = 27;
  localparam int TidxW   = 10;
  localparam int FreqW   = 32;
  localparam int CntW    = 16;
  localparam int DivCntW = $clog2(FreqW);
  localparam int CfgIdxW = 2;

  localparam logic [LevelW-1:0] SampleMask = LevelW'((1 << SampleBits) - 1);
  localparam logic [IdxW-1:0]   TestLo     = IdxW'(WindowLen / 2);
  localparam logic [IdxW-1:0]   TestHi     = IdxW'(CaptureLen - WindowLen / 2);
  localparam logic [IdxW:0]     WindowSpan = (IdxW + 1)'(WindowLen);
  localparam logic [TidxW-1:0]  NoTrigIdx  = TidxW'(WindowLen);
  localparam logic [FreqW-1:0]  FreqNum    = FreqW'(500000000);
  localparam logic [IdxW-1:0]   IdxMax     = '1;
  localparam logic [CntW-1:0]   CntMax     = '1;
  localparam logic [DivCntW-1:0] DivLast   = DivCntW'(FreqW - 1);

  localparam logic [ModeW-1:0] ModeOff  = 2'd0;
  localparam logic [ModeW-1:0] ModeFall = 2'd1;
  localparam logic [ModeW-1:0] ModeRise = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgLevel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMode  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTbase = 2'd2;

  localparam logic [LevelW-1:0] LevelReset = LevelW'(2048);
  localparam logic [TbW-1:0]    TbaseReset = TbW'(1);

  typedef struct packed {
    logic [LevelW-1:0] sample;
    logic              last;
  } etf_in_t;

  typedef struct packed {
    logic [TidxW-1:0] trigger_index;
    logic             untriggered;
    logic [FreqW-1:0] frequency;
  } etf_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_Q,
    S_MUL,
    S_DIV_F,
    S_DONE
  } etf_state_e;

endpackage

[src/edge_trigger_and_frequency_finder.sv]
// Top level of the edge trigger and frequency finder with its shared divider sequencer.
//
//   channel   direction  handshake            payload
//   in        input      in_valid_i/in_ready_o  etf_in_t (sample, last)
//   out       output     out_valid_o/out_ready_i etf_out_t (index, flag, frequency)
//   cfg       input      cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A sample that is not flagged last leaves the input ready for the next sample.
// A last sample holds the input while a frequency is computed: one check,
// a 32-step pass of the shared restoring divider, one multiply, a second 32-step pass
// and a load of the result; otherwise it holds it only for the check and the load.
// The load waits while the previous result is still held in the result register.
// Reset clears the configuration to its defaults and the capture state to zero.
`include "edge_trigger_and_frequency_finder_assert.svh"

module edge_trigger_and_frequency_finder
  import etf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  etf_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output etf_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TbW-1:0]     cfg_wdata_i
);

  etf_state_e state_q, state_d;

  logic [LevelW-1:0] level_q;
  logic [ModeW-1:0]  mode_q;
  logic [TbW-1:0]    tbase_q;

  logic [IdxW-1:0]   idx_q, idx_d;
  logic [LevelW-1:0] prev_q, prev_d;
  logic [IdxW-1:0]   first_q, first_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;

  logic [FreqW-1:0]   quo_q, quo_d;
  logic [FreqW-1:0]   rem_q, rem_d;
  logic [FreqW-1:0]   dvs_q, dvs_d;
  logic [DivCntW-1:0] step_q, step_d;

  logic     out_valid_q, out_valid_d;
  etf_out_t out_data_q, out_data_d;

  logic [LevelW-1:0]      smp, lvl;
  logic                   in_range, hit, beyond;
  logic [IdxW:0]          limit;
  logic [FreqW:0]         rem_sh, diff;
  logic [FreqW+CntW-1:0]  prod;
  logic                   in_acc, can_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign can_load    = !out_valid_q || out_ready_i;

  always_comb begin
    smp      = in_data_i.sample & SampleMask;
    lvl      = level_q & SampleMask;
    in_range = (idx_q >= TestLo) && (idx_q < TestHi);
    if (mode_q == ModeFall) begin
      hit = (smp <= lvl) && (prev_q > lvl);
    end else begin
      hit = (smp >= lvl) && (prev_q < lvl);
    end
    limit  = {1'b0, first_q} + WindowSpan;
    beyond = {1'b0, idx_q} > limit;
    rem_sh = {rem_q, quo_q[FreqW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    prod   = quo_q * (cnt_q - CntW'(1));
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    first_d     = first_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    step_d      = step_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!done_q && mode_q != ModeOff && in_range && hit) begin
            if (beyond) begin
              done_d = 1'b1;
            end else begin
              if (cnt_q != '0) begin
                last_d = idx_q;
              end else begin
                first_d = idx_q;
              end
              if (cnt_q < CntMax) begin
                cnt_d = cnt_q + CntW'(1);
              end
            end
          end
          prev_d = smp;
          if (idx_q < IdxMax) begin
            idx_d = idx_q + IdxW'(1);
          end
          if (in_data_i.last) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        quo_d  = '0;
        if (cnt_q >= CntW'(2) && tbase_q != '0 && last_q > first_q) begin
          quo_d   = FreqNum;
          rem_d   = '0;
          dvs_d   = FreqW'(tbase_q);
          step_d  = '0;
          state_d = S_DIV_Q;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV_Q, S_DIV_F: begin
        if (!diff[FreqW]) begin
          rem_d = diff[FreqW-1:0];
          quo_d = {quo_q[FreqW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[FreqW-1:0];
          quo_d = {quo_q[FreqW-2:0], 1'b0};
        end
        step_d = step_q + DivCntW'(1);
        if (step_q == DivLast) begin
          state_d = (state_q == S_DIV_Q) ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        quo_d   = prod[FreqW-1:0];
        rem_d   = '0;
        dvs_d   = FreqW'(last_q - first_q);
        step_d  = '0;
        state_d = S_DIV_F;
      end
      S_DONE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          if (cnt_q == '0) begin
            out_data_d.trigger_index = NoTrigIdx;
            out_data_d.untriggered   = 1'b1;
            out_data_d.frequency     = '0;
          end else begin
            out_data_d.trigger_index = first_q[TidxW-1:0];
            out_data_d.untriggered   = 1'b0;
            out_data_d.frequency     = quo_q;
          end
          idx_d   = '0;
          prev_d  = '0;
          first_d = '0;
          last_d  = '0;
          cnt_d   = '0;
          done_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      prev_q      <= '0;
      first_q     <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= LevelReset;
      mode_q      <= ModeOff;
      tbase_q     <= TbaseReset;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      prev_q      <= prev_d;
      first_q     <= first_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgLevel: level_q <= cfg_wdata_i[LevelW-1:0];
          CfgMode:  mode_q  <= cfg_wdata_i[ModeW-1:0];
          CfgTbase: tbase_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    step_q     <= step_d;
    out_data_q <= out_data_d;
  end

  `ETF_ASSERT_NEXT(a_last_starts_check, clk_i, rst_ni, in_acc && in_data_i.last,
                   state_q == S_CHECK, "last beat did not start the result sequence")
  `ETF_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE),
              "result appeared outside the load state")
  `ETF_ASSERT_NEXT(a_div_to_mul, clk_i, rst_ni, state_q == S_DIV_Q && step_q == DivLast,
                   state_q == S_MUL, "first division did not hand over to the multiply")
  `ETF_ASSERT(a_span_positive, clk_i, rst_ni, (cnt_q >= CntW'(2)) |-> (last_q > first_q),
              "crossing span is not positive with two or more crossings")
  `ETF_ASSERT_NEXT(a_out_taken, clk_i, rst_ni,
                   out_valid_q && out_ready_i && state_q != S_DONE, !out_valid_q,
                   "result beat repeated after it was taken")

endmodule

[sim/tb.sv]
// Self-checking testbench for the edge trigger and frequency finder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etf_pkg::*;

  localparam int DrainCycles = 80;
  localparam int MaxPrinted  = 50;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  etf_in_t            in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  etf_out_t           out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgLevel;
  logic [TbW-1:0]     cfg_wdata_i = '0;

  edge_trigger_and_frequency_finder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  logic [LevelW-1:0] cur_level = LevelReset;
  logic [ModeW-1:0]  trig_mode = ModeOff;
  logic [TbW-1:0]    time_base = TbaseReset;

  int unsigned sample_idx;
  int unsigned prev_sample;
  int unsigned first_cross;
  int unsigned last_cross;
  int unsigned cross_count;
  bit          search_stopped;

  etf_out_t pending_results[$];
  int       mismatches;
  int       beats_sent;
  bit       sender_idle_on = 1'b1;
  bit       stall_on = 1'b1;
  int       hold_request;
  int       hold_left;
  int       stall_left;

  function automatic void clear_capture();
    sample_idx     = 0;
    prev_sample    = 0;
    first_cross    = 0;
    last_cross     = 0;
    cross_count    = 0;
    search_stopped = 1'b0;
  endfunction

  function automatic void predict_sample(logic [LevelW-1:0] s, logic is_last);
    etf_out_t    res;
    bit          hit;
    logic [31:0] quot;
    logic [31:0] prod;
    if (!search_stopped && trig_mode != ModeOff && sample_idx >= WindowLen / 2 &&
        sample_idx < CaptureLen - WindowLen / 2) begin
      if (trig_mode == ModeFall) begin
        hit = (s <= cur_level) && (prev_sample > cur_level);
      end else begin
        hit = (s >= cur_level) && (prev_sample < cur_level);
      end
      if (hit) begin
        if (sample_idx > first_cross + WindowLen) begin
          search_stopped = 1'b1;
        end else begin
          if (cross_count != 0) last_cross = sample_idx;
          else first_cross = sample_idx;
          if (cross_count < 65535) cross_count++;
        end
      end
    end
    prev_sample = s;
    if (sample_idx < 65535) sample_idx++;
    if (is_last) begin
      res = '0;
      if (cross_count == 0) begin
        res.trigger_index = TidxW'(WindowLen);
        res.untriggered   = 1'b1;
      end else begin
        res.trigger_index = TidxW'(first_cross);
        if (cross_count >= 2 && time_base != 0 && last_cross > first_cross) begin
          quot = 32'd500000000 / 32'(time_base);
          prod = quot * 32'(cross_count - 1);
          res.frequency = prod / 32'(last_cross - first_cross);
        end
      end
      pending_results.push_back(res);
      clear_capture();
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    etf_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.trigger_index !== want.trigger_index)
          report_mismatch($sformatf("trigger_index %0d, expected %0d",
                                    out_data_o.trigger_index, want.trigger_index));
        if (out_data_o.untriggered !== want.untriggered)
          report_mismatch($sformatf("untriggered %0b, expected %0b",
                                    out_data_o.untriggered, want.untriggered));
        if (out_data_o.frequency !== want.frequency)
          report_mismatch($sformatf("frequency %0d, expected %0d",
                                    out_data_o.frequency, want.frequency));
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_beat(logic [LevelW-1:0] s, logic is_last);
    @(negedge clk_i);
    if (sender_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: s, last: is_last};
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    beats_sent++;
    predict_sample(s, is_last);
  endtask

  task automatic send_wave(int len, int halfp, int phase, logic [LevelW-1:0] lo,
                           logic [LevelW-1:0] hi, int noise_pct, bit with_last);
    logic [LevelW-1:0] s;
    for (int i = 0; i < len; i++) begin
      s = (((i + phase) / halfp) % 2 == 1) ? hi : lo;
      if ($urandom_range(0, 99) < noise_pct) s = LevelW'($urandom_range(0, 4095));
      send_beat(s, with_last && (i == len - 1));
    end
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TbW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgLevel: cur_level = value[LevelW-1:0];
      CfgMode:  trig_mode = value[ModeW-1:0];
      CfgTbase: time_base = value;
      default: ;
    endcase
  endtask

  task automatic randomize_config();
    logic [TbW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = TbW'(4095);
      default: v = TbW'($urandom_range(0, 4095));
    endcase
    if ($urandom_range(0, 3) == 0) v[TbW-1:LevelW] = (TbW - LevelW)'($urandom);
    write_reg(CfgLevel, v);
    v = TbW'($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) v[TbW-1:ModeW] = (TbW - ModeW)'($urandom);
    write_reg(CfgMode, v);
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = TbW'(1);
      3, 4:    v = TbW'($urandom_range(1, 1000));
      default: v = TbW'($urandom_range(1, 100000000));
    endcase
    write_reg(CfgTbase, v);
  endtask

  task automatic send_random_capture();
    int len;
    int lo_v;
    int hi_v;
    int kind;
    kind = $urandom_range(0, 9);
    len = $urandom_range(129, 140);
    if (kind <= 3) begin
      send_wave($urandom_range(1, 20), 1, 0, '0, '0, 100, 1'b1);
    end else if (kind == 4) begin
      send_wave(len, 1, 0, '0, '0, 100, 1'b1);
    end else if (kind == 9) begin
      send_wave(len, 1, 0, cur_level, cur_level, 0, 1'b1);
    end else begin
      lo_v = int'(cur_level) - $urandom_range(0, 400);
      hi_v = int'(cur_level) + $urandom_range(0, 400);
      if (lo_v < 0) lo_v = 0;
      if (hi_v > 4095) hi_v = 4095;
      send_wave(len, $urandom_range(1, 6), $urandom_range(0, 11), LevelW'(lo_v),
                LevelW'(hi_v), $urandom_range(0, 3) == 0 ? 5 : 0, 1'b1);
    end
  endtask

  task automatic test_reset_values();
    send_beat(12'hFFF, 1'b1);
    send_beat(12'h000, 1'b0);
    send_beat(12'hFFF, 1'b1);
    wait_idle();
    write_reg(CfgMode, TbW'(ModeRise));
    send_wave(131, 1, 1, 12'd2047, 12'd2048, 0, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(CfgLevel, '1);
    write_reg(CfgMode, '1);
    write_reg(CfgTbase, '1);
    send_wave(131, 1, 1, 12'h000, 12'hFFF, 0, 1'b1);
  endtask

  task automatic test_search_window();
    wait_idle();
    write_reg(CfgLevel, TbW'(2048));
    write_reg(CfgMode, TbW'(ModeRise));
    write_reg(CfgTbase, TbW'(1000));
    send_wave(258, 257, 0, 12'h000, 12'hFFF, 0, 1'b1);
  endtask

  task automatic test_mode_change();
    wait_idle();
    write_reg(CfgTbase, TbW'(1));
    send_wave(129, 1, 1, 12'd100, 12'd4000, 0, 1'b0);
    wait_idle();
    write_reg(CfgLevel, '0);
    write_reg(CfgMode, TbW'(ModeFall));
    write_reg(CfgTbase, '0);
    send_wave(4, 1, 130, 12'd0, 12'd4000, 0, 1'b1);
  endtask

  task automatic test_output_backpressure();
    wait_results();
    hold_request = 600;
    for (int n = 0; n < 15; n++) send_wave($urandom_range(1, 4), 1, 0, '0, '0, 100, 1'b1);
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 3; n++) send_wave($urandom_range(1, 6), 1, 0, '0, '0, 100, 1'b1);
    wait_results();
    for (int n = 0; n < 3; n++) send_wave($urandom_range(1, 6), 1, 0, '0, '0, 100, 1'b1);
  endtask

  task automatic test_random_captures();
    int beats_at_start;
    beats_at_start = beats_sent;
    while (beats_sent - beats_at_start < 120) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        randomize_config();
      end
      send_random_capture();
    end
  endtask

  task automatic test_full_rate();
    sender_idle_on = 1'b0;
    stall_on = 1'b0;
    for (int n = 0; n < 5; n++) send_wave($urandom_range(1, 12), 1, 0, '0, '0, 100, 1'b1);
  endtask

  initial begin
    clear_capture();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_register_extremes();
    test_search_window();
    test_mode_change();
    test_output_backpressure();
    test_drain_pause();
    test_random_captures();
    test_full_rate();
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("edge_trigger_and_frequency_finder test passed");
    end else begin
      $display("edge_trigger_and_frequency_finder test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("edge_trigger_and_frequency_finder test failed");
    $finish;
  end

endmodule
